// ===== hw/rtl/mr64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr64_pkg
// Shared types, constants and the witness base table of the 64-bit
// Miller-Rabin primality core.
// ----------------------------------------------------------------------------
package mr64_pkg;

  // Candidate width, loop counter widths and witness table sizes.
  localparam int unsigned CandW        = 63;
  localparam int unsigned CntW         = 6;
  localparam int unsigned MaxWitnesses = 12;
  localparam int unsigned IdxW         = 4;
  localparam int unsigned BaseW        = 6;

  // Operand selection of the shared modular multiplier.
  typedef enum logic [1:0] {
    MUL_XB = 2'd0,   // x * b, result written to x
    MUL_BB = 2'd1,   // b * b, result written to b
    MUL_XX = 2'd2    // x * x, result written to x
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_cand;
    logic     dec_init;
    logic     dec_shift;
    logic     base_init;
    logic     base_next;
    logic     pow_init;
    logic     e_shift;
    logic     r_init;
    logic     r_inc;
    logic     mul_start;
    mul_sel_e mul_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lt2;
    logic two_or_three;
    logic even;
    logic d_odd;
    logic base_ge_n;
    logic e_zero;
    logic e_lsb;
    logic mul_busy;
    logic mul_done;
    logic x_one;
    logic x_nm1;
    logic r_lt_s;
    logic base_last;
  } sts_t;

  // Witness bases 2 to 37 in order.
  function automatic logic [BaseW-1:0] base_of(input logic [IdxW-1:0] idx);
    logic [BaseW-1:0] b;
    unique case (idx)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd37;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/mr64_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr64_datapath
// Candidate, exponent, power and counter registers with a bit-serial
// double-and-add modular multiplier that retires one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module mr64_datapath #(
  parameter int unsigned NUM_WITNESSES = mr64_pkg::MaxWitnesses
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mr64_pkg::CandW-1:0]  candidate_i,
  input  mr64_pkg::cmd_t              cmd_i,
  output mr64_pkg::sts_t              sts_o
);

  localparam int unsigned W = mr64_pkg::CandW;

  logic [W-1:0]                 n_q, nm1_q, d_q, e_q, x_q, b_q;
  logic [mr64_pkg::CntW-1:0]    s_q, r_q;
  logic [mr64_pkg::IdxW-1:0]    idx_q;

  // Multiplier state.
  logic                         mbusy_q;
  logic [mr64_pkg::CntW-1:0]    mcnt_q;
  logic [W-1:0]                 ma_q, mb_q, acc_q;
  mr64_pkg::mul_sel_e           msel_q;

  logic [W:0]                   sh, sh_r, ad, ad_r;
  logic [W-1:0]                 base_val;
  logic                         mul_last;

  assign base_val = W'(mr64_pkg::base_of(idx_q));
  assign mul_last = mbusy_q && (mcnt_q == '0);

  // One double-and-add step: acc = 2*acc mod n, then add ma if the bit is set.
  always_comb begin
    sh   = {acc_q, 1'b0};
    sh_r = (sh >= {1'b0, n_q}) ? sh - {1'b0, n_q} : sh;
    ad   = sh_r + (mb_q[W-1] ? {1'b0, ma_q} : '0);
    ad_r = (ad >= {1'b0, n_q}) ? ad - {1'b0, n_q} : ad;
  end

  // Decomposition and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q   <= '0;
      r_q   <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.dec_init)  s_q   <= '0;
      else if (cmd_i.dec_shift) s_q <= s_q + 1'b1;
      if (cmd_i.r_init)    r_q   <= mr64_pkg::CntW'(1);
      else if (cmd_i.r_inc) r_q  <= r_q + 1'b1;
      if (cmd_i.base_init) idx_q <= '0;
      else if (cmd_i.base_next) idx_q <= idx_q + 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cand) begin
      n_q   <= candidate_i;
      nm1_q <= candidate_i - 1'b1;
    end
    if (cmd_i.dec_init)       d_q <= nm1_q;
    else if (cmd_i.dec_shift) d_q <= d_q >> 1;
    if (cmd_i.pow_init)       e_q <= d_q;
    else if (cmd_i.e_shift)   e_q <= e_q >> 1;
    if (cmd_i.pow_init) begin
      x_q <= W'(1);
      b_q <= base_val;
    end else if (mul_last) begin
      if (msel_q == mr64_pkg::MUL_BB) b_q <= ad_r[W-1:0];
      else                            x_q <= ad_r[W-1:0];
    end
  end

  // Multiplier sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mcnt_q  <= '0;
    end else if (cmd_i.mul_start) begin
      mbusy_q <= 1'b1;
      mcnt_q  <= mr64_pkg::CntW'(W - 1);
    end else if (mbusy_q) begin
      mcnt_q <= mcnt_q - 1'b1;
      if (mul_last) mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      acc_q  <= '0;
      msel_q <= cmd_i.mul_sel;
      unique case (cmd_i.mul_sel)
        mr64_pkg::MUL_XB: begin ma_q <= b_q; mb_q <= x_q; end
        mr64_pkg::MUL_BB: begin ma_q <= b_q; mb_q <= b_q; end
        mr64_pkg::MUL_XX: begin ma_q <= x_q; mb_q <= x_q; end
        default:          begin ma_q <= x_q; mb_q <= x_q; end
      endcase
    end else if (mbusy_q) begin
      acc_q <= ad_r[W-1:0];
      mb_q  <= mb_q << 1;
    end
  end

  // Status towards the controller.
  always_comb begin
    sts_o.lt2          = (n_q < W'(2));
    sts_o.two_or_three = (n_q == W'(2)) || (n_q == W'(3));
    sts_o.even         = ~n_q[0];
    sts_o.d_odd        = d_q[0];
    sts_o.base_ge_n    = (base_val >= n_q);
    sts_o.e_zero       = (e_q == '0);
    sts_o.e_lsb        = e_q[0];
    sts_o.mul_busy     = mbusy_q;
    sts_o.mul_done     = mul_last;
    sts_o.x_one        = (x_q == W'(1));
    sts_o.x_nm1        = (x_q == nm1_q);
    sts_o.r_lt_s       = (r_q < s_q);
    sts_o.base_last    = (idx_q == mr64_pkg::IdxW'(NUM_WITNESSES - 1));
  end

endmodule

// ===== hw/rtl/mr64_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mr64_ctrl
// Controller state machine that sequences the trivial checks, the n-1
// decomposition, the modular power and the squaring loop for each base.
// ----------------------------------------------------------------------------
module mr64_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output logic           done_o,
  output logic           prime_flag_o,
  output mr64_pkg::cmd_t cmd_o,
  input  mr64_pkg::sts_t sts_i
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_CHECK  = 12'b0000_0000_0010,
    ST_DECOMP = 12'b0000_0000_0100,
    ST_BASE   = 12'b0000_0000_1000,
    ST_PWCHK  = 12'b0000_0001_0000,
    ST_PWMUL  = 12'b0000_0010_0000,
    ST_PWBB   = 12'b0000_0100_0000,
    ST_PWSQ   = 12'b0000_1000_0000,
    ST_TEST   = 12'b0001_0000_0000,
    ST_SQCHK  = 12'b0010_0000_0000,
    ST_SQMUL  = 12'b0100_0000_0000,
    ST_DONE   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   res_q, res_d;

  // Next state and command decoding.
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.mul_sel = mr64_pkg::MUL_XB;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load_cand = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (sts_i.lt2) begin
          res_d = 1'b0; state_d = ST_DONE;
        end else if (sts_i.two_or_three) begin
          res_d = 1'b1; state_d = ST_DONE;
        end else if (sts_i.even) begin
          res_d = 1'b0; state_d = ST_DONE;
        end else begin
          cmd_o.dec_init = 1'b1;
          state_d = ST_DECOMP;
        end
      end
      ST_DECOMP: begin
        if (sts_i.d_odd) begin
          cmd_o.base_init = 1'b1;
          state_d = ST_BASE;
        end else begin
          cmd_o.dec_shift = 1'b1;
        end
      end
      ST_BASE: begin
        if (sts_i.base_ge_n) begin
          res_d = 1'b1; state_d = ST_DONE;
        end else begin
          cmd_o.pow_init = 1'b1;
          state_d = ST_PWCHK;
        end
      end
      ST_PWCHK: begin
        priority if (sts_i.e_zero) begin
          state_d = ST_TEST;
        end else if (sts_i.e_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = mr64_pkg::MUL_XB;
          state_d = ST_PWMUL;
        end else begin
          state_d = ST_PWBB;
        end
      end
      ST_PWMUL: begin
        if (sts_i.mul_done) state_d = ST_PWBB;
      end
      ST_PWBB: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = mr64_pkg::MUL_BB;
        state_d = ST_PWSQ;
      end
      ST_PWSQ: begin
        if (sts_i.mul_done) begin
          cmd_o.e_shift = 1'b1;
          state_d = ST_PWCHK;
        end
      end
      ST_TEST: begin
        if (sts_i.x_one || sts_i.x_nm1) begin
          if (sts_i.base_last) begin
            res_d = 1'b1; state_d = ST_DONE;
          end else begin
            cmd_o.base_next = 1'b1;
            state_d = ST_BASE;
          end
        end else begin
          cmd_o.r_init = 1'b1;
          state_d = ST_SQCHK;
        end
      end
      // After a squaring only n-1 ends the base as passed; a value of one
      // keeps squaring until the count runs out.
      ST_SQCHK: begin
        priority if (sts_i.x_nm1) begin
          if (sts_i.base_last) begin
            res_d = 1'b1; state_d = ST_DONE;
          end else begin
            cmd_o.base_next = 1'b1;
            state_d = ST_BASE;
          end
        end else if (sts_i.r_lt_s) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = mr64_pkg::MUL_XX;
          state_d = ST_SQMUL;
        end else begin
          res_d = 1'b0; state_d = ST_DONE;
        end
      end
      ST_SQMUL: begin
        if (sts_i.mul_done) begin
          cmd_o.r_inc = 1'b1;
          state_d = ST_SQCHK;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = (state_q == ST_DONE);
  assign prime_flag_o = res_q;

  // A result strobe lasts exactly one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  // An accepted item makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  // A product is never started while the multiplier is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |-> !sts_i.mul_busy)
    else $error("multiplier restarted while busy");
  // A completion is only seen while waiting on the multiplier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> (state_q == ST_PWMUL || state_q == ST_PWSQ || state_q == ST_SQMUL))
    else $error("product completed in an unexpected state");

endmodule

// ===== hw/rtl/miller_rabin_primality_64_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_primality_64_core
// Deterministic Miller-Rabin primality test of a 63-bit candidate.
// ----------------------------------------------------------------------------
// Usage: drive candidate_i and raise start while busy is low; that edge is the
// transfer of the candidate. busy stays high until the result is shown.
// prime_flag_o is valid for exactly one cycle while done_o is high; the
// receiver cannot stall it, so it must take the result in that cycle.
// busy falls in the cycle after the strobe, and the next candidate may then be
// transferred.
// Flow: candidates below 2, two, three and even values pass from the check state
// straight to the done state. Other values strip the trailing zeros of n-1, then
// for each base run one modular product per exponent bit and per set bit plus up
// to s-1 squarings. Each product runs on one shared bit-serial multiplier.
// Reset clears the controller to idle; no state survives between candidates.
// ----------------------------------------------------------------------------
module miller_rabin_primality_64_core #(
  parameter int unsigned NUM_WITNESSES = mr64_pkg::MaxWitnesses
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [mr64_pkg::CandW-1:0] candidate_i,
  output logic                       done_o,
  output logic                       prime_flag_o
);

  mr64_pkg::cmd_t cmd;
  mr64_pkg::sts_t sts;

  // Sequencing.
  mr64_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .done_o       (done_o),
    .prime_flag_o (prime_flag_o),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // Arithmetic.
  mr64_datapath #(
    .NUM_WITNESSES (NUM_WITNESSES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .candidate_i (candidate_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== tb/sv/miller_rabin_primality_64_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_primality_64_checker
// Watches the candidate and result channels of the primality core, works out
// the expected verdict of every transferred candidate and compares each
// strobed result with the oldest verdict still waiting.
// ----------------------------------------------------------------------------
module miller_rabin_primality_64_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [mr64_pkg::CandW-1:0] candidate_i,
  input  logic                       done_i,
  input  logic                       prime_flag_i,
  output int                         fail_count_o,
  output int                         verdicts_waiting_o
);

  typedef logic [mr64_pkg::CandW-1:0] cand_t;

  // Bases tried in order, as the core tables them.
  localparam int unsigned BaseTab [mr64_pkg::MaxWitnesses] =
    '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

  bit verdict_q [$];

  // Exact product modulo m through a double-width multiply.
  function automatic cand_t mul_mod(cand_t a, cand_t b, cand_t m);
    logic [2*mr64_pkg::CandW-1:0] prod;
    prod = {{mr64_pkg::CandW{1'b0}}, a} * {{mr64_pkg::CandW{1'b0}}, b};
    return cand_t'(prod % {{mr64_pkg::CandW{1'b0}}, m});
  endfunction

  function automatic cand_t pow_mod(cand_t base, cand_t e, cand_t m);
    cand_t acc;
    cand_t sq;
    acc = cand_t'(1);
    sq  = base % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, sq, m);
      sq = mul_mod(sq, sq, m);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit predict_verdict(cand_t n);
    cand_t d;
    cand_t nm1;
    cand_t x;
    int    s;
    bit    witness_found;
    if (n < 2) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    if (!n[0]) return 1'b0;
    nm1 = n - cand_t'(1);
    d   = nm1;
    s   = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < mr64_pkg::MaxWitnesses; i++) begin
      if (cand_t'(BaseTab[i]) >= n) break;
      x = pow_mod(cand_t'(BaseTab[i]), d, n);
      if (x == 1 || x == nm1) continue;
      witness_found = 1'b1;
      for (int r = 1; r < s; r++) begin
        x = mul_mod(x, x, n);
        if (x == nm1) begin
          witness_found = 1'b0;
          break;
        end
      end
      if (witness_found) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Record each candidate transfer and check each strobed result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o       <= 0;
      verdicts_waiting_o <= 0;
    end else begin
      if (done_i) begin
        if (verdict_q.size() == 0) begin
          $error("prime_flag: unexpected result, actual %0d", prime_flag_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (prime_flag_i !== verdict_q[0]) begin
            $error("prime_flag: expected %0d, actual %0d", verdict_q[0], prime_flag_i);
            fail_count_o <= fail_count_o + 1;
          end
          void'(verdict_q.pop_front());
        end
      end
      if (start_i && !busy_i) verdict_q.push_back(predict_verdict(candidate_i));
      verdicts_waiting_o <= verdict_q.size();
    end
  end

endmodule

// ===== tb/sv/miller_rabin_primality_64_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_primality_64_core_tb
// Drives directed and random candidates into the primality core with random
// gaps and leaves the checking of every verdict to the checker beside it.
// ----------------------------------------------------------------------------
module miller_rabin_primality_64_core_tb;

  localparam longint CycleLimit = 60000000;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [mr64_pkg::CandW-1:0] candidate_i;
  logic                       done_o;
  logic                       prime_flag_o;
  int                         fail_count;
  int                         verdicts_waiting;
  longint                     cycle_count = 0;
  bit                         gaps_on;

  miller_rabin_primality_64_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .candidate_i (candidate_i),
    .done_o      (done_o),
    .prime_flag_o(prime_flag_o)
  );

  miller_rabin_primality_64_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .candidate_i       (candidate_i),
    .done_i            (done_o),
    .prime_flag_i      (prime_flag_o),
    .fail_count_o      (fail_count),
    .verdicts_waiting_o(verdicts_waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("miller_rabin_primality_64_core_tb: FAIL");
      $finish;
    end
  end

  // One candidate transfer, with an occasional gap afterwards.
  task automatic send_candidate(logic [mr64_pkg::CandW-1:0] n);
    start       <= 1'b1;
    candidate_i <= n;
    do @(posedge clk_i); while (busy);
    if (gaps_on && $urandom_range(99) < 11) begin
      start       <= 1'b0;
      candidate_i <= mr64_pkg::CandW'({$urandom, $urandom});
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [mr64_pkg::CandW-1:0] random_candidate();
    int unsigned sel;
    logic [mr64_pkg::CandW-1:0] v;
    sel = $urandom_range(99);
    v   = mr64_pkg::CandW'({$urandom, $urandom});
    if (sel < 45) v = mr64_pkg::CandW'($urandom_range(4095));  // small, many primes
    else if (sel < 75) v[0] = 1'b0;                             // wide even values
    else if (sel < 97) v[0] = 1'b1;                             // wide odd, mostly composite
    else v = 63'd2305843009213693951;                           // a rare large prime
    return v;
  endfunction

  initial begin
    logic [mr64_pkg::CandW-1:0] directed [$];
    gaps_on     = 1'b0;
    start       = 1'b0;
    candidate_i = '0;
    rst_ni      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, the trivial cases, bases reaching the candidate and
    // strong pseudoprimes to the first bases.
    directed = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd7, 63'd9, 63'd25,
                 63'd37, 63'd41, 63'd561, 63'd2047, 63'd1373653, 63'd25326001,
                 63'd3215031751, 63'd3825123056546413051, {mr64_pkg::CandW{1'b1}},
                 {{(mr64_pkg::CandW-1){1'b1}}, 1'b0}, 63'd9223372036854775783,
                 63'd1000000007, 63'd4294967297};
    foreach (directed[i]) send_candidate(directed[i]);

    // Let everything drain before the random part.
    start <= 1'b0;
    do @(posedge clk_i); while (verdicts_waiting != 0 || busy);

    // First half back to back, second half with gaps.
    for (int i = 0; i < 80; i++) begin
      gaps_on = (i >= 40);
      send_candidate(random_candidate());
    end
    start <= 1'b0;

    do @(posedge clk_i); while (verdicts_waiting != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("miller_rabin_primality_64_core_tb: PASS");
    end else begin
      $display("miller_rabin_primality_64_core_tb: FAIL");
    end
    $finish;
  end

endmodule
